### src/gasp_pkg.sv
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared constants, codes and interface structs of the grid A* path search.
// ----------------------------------------------------------------------------
package gasp_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int COORD_W    = 6;
    localparam int SIDE_W     = 7;
    localparam int CELL_W     = 12;
    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int LEN_W      = 13;
    localparam int IDX_W      = 12;

    localparam int DEF_POOL_DEPTH = 16384;
    localparam int DEF_HEAP_DEPTH = 16384;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_PATH  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    localparam logic [1:0] CFG_LOWEST_FIRST = 2'd0;
    localparam logic [1:0] CFG_GRID_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] gx;
        logic [COORD_W-1:0] gy;
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
        logic               lowest_first;
    } search_cmd_t;

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   length;
    } search_res_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [CELL_W-1:0]  data;
    } path_wr_t;

    function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0) r = SIDE_W'(1);
        else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
        return r;
    endfunction

endpackage

### src/gasp_ram.sv
// ----------------------------------------------------------------------------
// gasp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gasp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/gasp_engine.sv
// ----------------------------------------------------------------------------
// gasp_engine
// A* search sequencer: cell state memory, node pool and binary open heap.
// ----------------------------------------------------------------------------
module gasp_engine #(
    parameter int POOL_DEPTH = gasp_pkg::DEF_POOL_DEPTH,
    parameter int HEAP_DEPTH = gasp_pkg::DEF_HEAP_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  gasp_pkg::search_cmd_t         cmd,
    output logic                          done,
    output gasp_pkg::search_res_t         res,
    output logic [gasp_pkg::CELL_W-1:0]   occ_raddr,
    input  logic                          occ_rdata,
    output gasp_pkg::path_wr_t            path_wr
);

    localparam int PW   = $clog2(POOL_DEPTH);
    localparam int HW   = $clog2(HEAP_DEPTH);
    localparam int GW   = PW + 1;
    localparam int FW   = GW + 1;
    localparam int CW   = gasp_pkg::CELL_W;
    localparam int XW   = gasp_pkg::COORD_W;
    localparam int SW   = gasp_pkg::SIDE_W;
    localparam int LW   = gasp_pkg::LEN_W;
    localparam int CSD  = gasp_pkg::CELL_COUNT;

    typedef struct packed {
        logic [CW-1:0] loc;
        logic [GW-1:0] g;
        logic [PW-1:0] parent;
        logic          has_parent;
    } rec_t;

    typedef struct packed {
        logic [FW-1:0] f;
        logic [PW-1:0] node;
    } key_t;

    typedef struct packed {
        logic          closed;
        logic          valid;
        logic [GW-1:0] g;
    } cstate_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_PUSH, S_UP_CHK, S_UP_CMP, S_POP, S_POP_TOP, S_POP_LAST,
        S_DN_CHK, S_DN_C0, S_DN_C1, S_DN_CMP, S_RD_NODE, S_NODE, S_DIR, S_CHK,
        S_NEXT, S_KEEP, S_KEEP_W, S_KEEP_R, S_DONE
    } state_t;

    function automatic logic goes_first(input key_t a, input key_t b, input logic lf);
        logic r;
        if (a.f != b.f) r = lf ? (a.f < b.f) : (a.f > b.f);
        else r = a.node < b.node;
        return r;
    endfunction

    function automatic logic [XW-1:0] absdiff(input logic [XW-1:0] a, input logic [XW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    state_t                 state_reg, state_next;
    gasp_pkg::search_cmd_t  cmd_reg, cmd_next;
    logic [PW:0]            pool_cnt_reg, pool_cnt_next;
    logic [HW:0]            heap_cnt_reg, heap_cnt_next;
    logic [HW-1:0]          hi_reg, hi_next;
    logic [HW+1:0]          c_reg, c_next;
    key_t                   key_reg, key_next;
    key_t                   cand_reg, cand_next;
    key_t                   top_reg, top_next;
    rec_t                   cur_reg, cur_next;
    logic [PW-1:0]          cur_node_reg, cur_node_next;
    logic [1:0]             dir_reg, dir_next;
    logic                   from_start_reg, from_start_next;
    logic [CW:0]            clr_reg, clr_next;
    logic [LW-1:0]          k_reg, k_next;
    gasp_pkg::status_t      status_reg, status_next;
    logic [LW-1:0]          len_reg, len_next;
    rec_t                   p_reg, p_next;

    logic                   pool_we;
    logic [PW-1:0]          pool_waddr, pool_raddr;
    rec_t                   pool_wdata, pool_rdata;
    logic                   heap_we;
    logic [HW-1:0]          heap_waddr, heap_raddr;
    key_t                   heap_wdata, heap_rdata;
    logic                   cs_we;
    logic [CW-1:0]          cs_waddr, cs_raddr;
    cstate_t                cs_wdata, cs_rdata;

    logic [XW-1:0]          cx, cy;
    logic [SW-1:0]          nx, ny;
    logic                   n_in;
    logic [CW-1:0]          nc;
    logic [GW-1:0]          tg;
    logic [FW-1:0]          p_f;
    logic [HW-1:0]          up;
    logic [HW+1:0]          c_new;
    state_t                 ret_state;

    gasp_ram #(.WIDTH($bits(rec_t)), .DEPTH(POOL_DEPTH)) u_pool (
        .aclk(aclk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
        .raddr(pool_raddr), .rdata(pool_rdata)
    );

    gasp_ram #(.WIDTH($bits(key_t)), .DEPTH(HEAP_DEPTH)) u_heap (
        .aclk(aclk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    gasp_ram #(.WIDTH($bits(cstate_t)), .DEPTH(CSD)) u_cstate (
        .aclk(aclk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata)
    );

    assign cx    = cur_reg.loc[XW-1:0];
    assign cy    = cur_reg.loc[CW-1:XW];
    assign tg    = cur_reg.g + GW'(1);
    assign p_f   = FW'(p_reg.g)
                 + FW'(absdiff(p_reg.loc[XW-1:0], cmd_reg.gx))
                 + FW'(absdiff(p_reg.loc[CW-1:XW], cmd_reg.gy));
    assign up    = (hi_reg - HW'(1)) >> 1;
    assign c_new = {1'b0, hi_reg, 1'b1};
    assign ret_state = from_start_reg ? S_POP : S_NEXT;
    assign nc    = {ny[XW-1:0], nx[XW-1:0]};

    always_comb begin
        nx   = {1'b0, cx};
        ny   = {1'b0, cy};
        n_in = 1'b0;
        unique case (dir_reg)
            2'd0: begin
                nx   = {1'b0, cx} + SW'(1);
                n_in = nx < cmd_reg.w;
            end
            2'd1: begin
                nx   = {1'b0, cx} - SW'(1);
                n_in = cx != '0;
            end
            2'd2: begin
                ny   = {1'b0, cy} + SW'(1);
                n_in = ny < cmd_reg.h;
            end
            default: begin
                ny   = {1'b0, cy} - SW'(1);
                n_in = cy != '0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pool_cnt_next   = pool_cnt_reg;
        heap_cnt_next   = heap_cnt_reg;
        hi_next         = hi_reg;
        c_next          = c_reg;
        key_next        = key_reg;
        cand_next       = cand_reg;
        top_next        = top_reg;
        cur_next        = cur_reg;
        cur_node_next   = cur_node_reg;
        dir_next        = dir_reg;
        from_start_next = from_start_reg;
        clr_next        = clr_reg;
        k_next          = k_reg;
        status_next     = status_reg;
        len_next        = len_reg;
        p_next          = p_reg;

        pool_we    = 1'b0;
        pool_waddr = pool_cnt_reg[PW-1:0];
        pool_wdata = p_reg;
        pool_raddr = top_reg.node;
        heap_we    = 1'b0;
        heap_waddr = hi_reg;
        heap_wdata = key_reg;
        heap_raddr = '0;
        cs_we      = 1'b0;
        cs_waddr   = p_reg.loc;
        cs_wdata   = '{closed: 1'b0, valid: 1'b1, g: p_reg.g};
        cs_raddr   = nc;
        occ_raddr  = nc;
        path_wr    = '{en: 1'b0, addr: k_reg[CW-1:0] - CW'(1), data: cur_reg.loc};
        done       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd_next    = cmd;
                    len_next    = '0;
                    clr_next    = '0;
                    if ({1'b0, cmd.sx} >= cmd.w || {1'b0, cmd.sy} >= cmd.h ||
                        {1'b0, cmd.gx} >= cmd.w || {1'b0, cmd.gy} >= cmd.h) begin
                        status_next = gasp_pkg::ST_RANGE;
                        state_next  = S_DONE;
                    end else begin
                        state_next  = S_CLR;
                    end
                end
            end
            S_CLR: begin
                cs_we    = 1'b1;
                cs_waddr = clr_reg[CW-1:0];
                cs_wdata = '0;
                clr_next = clr_reg + (CW+1)'(1);
                if (clr_reg == (CW+1)'(CSD - 1)) begin
                    pool_cnt_next   = '0;
                    heap_cnt_next   = '0;
                    from_start_next = 1'b1;
                    p_next = '{loc: {cmd_reg.sy, cmd_reg.sx}, g: '0, parent: '0,
                               has_parent: 1'b0};
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (pool_cnt_reg >= (PW+1)'(POOL_DEPTH) ||
                    heap_cnt_reg >= (HW+1)'(HEAP_DEPTH)) begin
                    status_next = gasp_pkg::ST_OVERFLOW;
                    len_next    = '0;
                    state_next  = S_DONE;
                end else begin
                    pool_we       = 1'b1;
                    cs_we         = 1'b1;
                    key_next      = '{f: p_f, node: pool_cnt_reg[PW-1:0]};
                    hi_next       = heap_cnt_reg[HW-1:0];
                    heap_cnt_next = heap_cnt_reg + (HW+1)'(1);
                    pool_cnt_next = pool_cnt_reg + (PW+1)'(1);
                    state_next    = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                heap_raddr = up;
                if (hi_reg == '0) begin
                    heap_we    = 1'b1;
                    state_next = ret_state;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                heap_we = 1'b1;
                if (goes_first(key_reg, heap_rdata, cmd_reg.lowest_first)) begin
                    heap_wdata = heap_rdata;
                    hi_next    = up;
                    state_next = S_UP_CHK;
                end else begin
                    state_next = ret_state;
                end
            end
            S_POP: begin
                heap_raddr = '0;
                if (heap_cnt_reg == '0) begin
                    status_next = gasp_pkg::ST_NO_PATH;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_POP_TOP;
                end
            end
            S_POP_TOP: begin
                top_next      = heap_rdata;
                heap_cnt_next = heap_cnt_reg - (HW+1)'(1);
                heap_raddr    = heap_cnt_next[HW-1:0];
                if (heap_cnt_reg == (HW+1)'(1)) state_next = S_RD_NODE;
                else state_next = S_POP_LAST;
            end
            S_POP_LAST: begin
                key_next   = heap_rdata;
                hi_next    = '0;
                state_next = S_DN_CHK;
            end
            S_DN_CHK: begin
                heap_raddr = c_new[HW-1:0];
                c_next     = c_new;
                if (c_new >= {1'b0, heap_cnt_reg}) begin
                    heap_we    = 1'b1;
                    state_next = S_RD_NODE;
                end else begin
                    state_next = S_DN_C0;
                end
            end
            S_DN_C0: begin
                cand_next  = heap_rdata;
                heap_raddr = c_reg[HW-1:0] + HW'(1);
                if (c_reg + (HW+2)'(1) < {1'b0, heap_cnt_reg}) state_next = S_DN_C1;
                else state_next = S_DN_CMP;
            end
            S_DN_C1: begin
                if (goes_first(heap_rdata, cand_reg, cmd_reg.lowest_first)) begin
                    cand_next = heap_rdata;
                    c_next    = c_reg + (HW+2)'(1);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                heap_we = 1'b1;
                if (goes_first(cand_reg, key_reg, cmd_reg.lowest_first)) begin
                    heap_wdata = cand_reg;
                    hi_next    = c_reg[HW-1:0];
                    state_next = S_DN_CHK;
                end else begin
                    state_next = S_RD_NODE;
                end
            end
            S_RD_NODE: begin
                pool_raddr = top_reg.node;
                state_next = S_NODE;
            end
            S_NODE: begin
                cur_next      = pool_rdata;
                cur_node_next = top_reg.node;
                if (pool_rdata.loc == {cmd_reg.gy, cmd_reg.gx}) begin
                    state_next = S_KEEP;
                end else begin
                    cs_we      = 1'b1;
                    cs_waddr   = pool_rdata.loc;
                    cs_wdata   = '{closed: 1'b1, valid: 1'b0, g: '0};
                    dir_next   = 2'd0;
                    state_next = S_DIR;
                end
            end
            S_DIR: begin
                if (n_in) begin
                    p_next = '{loc: nc, g: tg, parent: cur_node_reg, has_parent: 1'b1};
                    state_next = S_CHK;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_CHK: begin
                if (occ_rdata || cs_rdata.closed || (cs_rdata.valid && tg >= cs_rdata.g)) begin
                    state_next = S_NEXT;
                end else begin
                    from_start_next = 1'b0;
                    state_next      = S_PUSH;
                end
            end
            S_NEXT: begin
                dir_next = dir_reg + 2'd1;
                if (dir_reg == 2'd3) state_next = S_POP;
                else state_next = S_DIR;
            end
            S_KEEP: begin
                if (int'(cur_reg.g) >= CSD) begin
                    status_next = gasp_pkg::ST_OVERFLOW;
                    len_next    = '0;
                    state_next  = S_DONE;
                end else begin
                    k_next     = LW'(cur_reg.g) + LW'(1);
                    len_next   = LW'(cur_reg.g) + LW'(1);
                    state_next = S_KEEP_W;
                end
            end
            S_KEEP_W: begin
                path_wr.en = 1'b1;
                k_next     = k_reg - LW'(1);
                pool_raddr = cur_reg.parent;
                if (!cur_reg.has_parent) begin
                    status_next = gasp_pkg::ST_OK;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_KEEP_R;
                end
            end
            S_KEEP_R: begin
                cur_next   = pool_rdata;
                state_next = S_KEEP_W;
            end
            S_DONE: begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign res = '{status: status_reg, length: len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cmd_reg        <= cmd_next;
        pool_cnt_reg   <= pool_cnt_next;
        heap_cnt_reg   <= heap_cnt_next;
        hi_reg         <= hi_next;
        c_reg          <= c_next;
        key_reg        <= key_next;
        cand_reg       <= cand_next;
        top_reg        <= top_next;
        cur_reg        <= cur_next;
        cur_node_reg   <= cur_node_next;
        dir_reg        <= dir_next;
        from_start_reg <= from_start_next;
        clr_reg        <= clr_next;
        k_reg          <= k_next;
        status_reg     <= status_next;
        len_reg        <= len_next;
        p_reg          <= p_next;
    end

endmodule

### src/grid_a_star_path_search_top.sv
// A search pops nodes off the open heap, tries each neighbor, sifts the heap up on
// a push and down on a pop, and at the goal walks the parents back to write the path.
// One request in flight; the next is taken once the result is registered.
// Reset: synchronous, active low; a pass then clears the grid,
// with no request taken. Each search also clears its cell state first.
// ----------------------------------------------------------------------------
// grid_a_star_path_search_top
// Grid A* path search: occupancy grid, path store, request control.
// ----------------------------------------------------------------------------
module grid_a_star_path_search_top #(
    parameter int POOL_DEPTH = gasp_pkg::DEF_POOL_DEPTH,
    parameter int HEAP_DEPTH = gasp_pkg::DEF_HEAP_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [5:0]  s_cell_x,
    input  logic [5:0]  s_cell_y,
    input  logic        s_occupied,
    input  logic [5:0]  s_goal_x,
    input  logic [5:0]  s_goal_y,
    input  logic [11:0] s_path_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [12:0] m_path_length,
    output logic [5:0]  m_step_x,
    output logic [5:0]  m_step_y
);

    localparam int CW = gasp_pkg::CELL_W;
    localparam int XW = gasp_pkg::COORD_W;
    localparam int LW = gasp_pkg::LEN_W;

    typedef enum logic [2:0] {T_CLR, T_IDLE, T_READ, T_SEARCH, T_RESP} state_t;

    state_t                 state_reg;
    logic [CW:0]            clr_reg;
    logic                   lowest_first_reg;
    logic [6:0]             grid_width_reg, grid_height_reg;
    logic [LW-1:0]          found_length_reg;
    gasp_pkg::status_t      res_status_reg;
    logic [XW-1:0]          res_x_reg, res_y_reg;
    logic                   eng_start_reg;
    gasp_pkg::search_cmd_t  cmd_reg;
    logic                   m_valid_reg;
    logic [1:0]             m_status_reg;
    logic [LW-1:0]          m_len_reg;
    logic [XW-1:0]          m_x_reg, m_y_reg;

    logic [6:0]             side_w, side_h;
    logic                   accept, in_grid;
    logic                   occ_we, occ_wdata, occ_rdata;
    logic [CW-1:0]          occ_waddr, occ_raddr;
    logic [CW-1:0]          path_rdata;
    logic                   eng_done;
    gasp_pkg::search_res_t  eng_res;
    gasp_pkg::path_wr_t     path_wr;

    assign side_w  = gasp_pkg::side_of(grid_width_reg);
    assign side_h  = gasp_pkg::side_of(grid_height_reg);
    assign s_ready = state_reg == T_IDLE;
    assign accept  = s_valid && s_ready;
    assign in_grid = {1'b0, s_cell_x} < side_w && {1'b0, s_cell_y} < side_h;

    always_comb begin
        occ_we    = 1'b0;
        occ_waddr = {s_cell_y, s_cell_x};
        occ_wdata = s_occupied;
        if (state_reg == T_CLR) begin
            occ_we    = 1'b1;
            occ_waddr = clr_reg[CW-1:0];
            occ_wdata = 1'b0;
        end else if (accept && s_opcode == gasp_pkg::OP_WRITE && in_grid) begin
            occ_we = 1'b1;
        end
    end

    gasp_ram #(.WIDTH(1), .DEPTH(gasp_pkg::CELL_COUNT)) u_occ (
        .aclk(aclk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
        .raddr(occ_raddr), .rdata(occ_rdata)
    );

    gasp_ram #(.WIDTH(CW), .DEPTH(gasp_pkg::CELL_COUNT)) u_path (
        .aclk(aclk), .we(path_wr.en), .waddr(path_wr.addr), .wdata(path_wr.data),
        .raddr(s_path_index), .rdata(path_rdata)
    );

    gasp_engine #(.POOL_DEPTH(POOL_DEPTH), .HEAP_DEPTH(HEAP_DEPTH)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .start(eng_start_reg), .cmd(cmd_reg),
        .done(eng_done), .res(eng_res), .occ_raddr(occ_raddr), .occ_rdata(occ_rdata),
        .path_wr(path_wr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= T_CLR;
            clr_reg          <= '0;
            lowest_first_reg <= 1'b1;
            grid_width_reg   <= 7'd64;
            grid_height_reg  <= 7'd64;
            found_length_reg <= '0;
            eng_start_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            eng_start_reg <= accept && s_opcode == gasp_pkg::OP_SEARCH;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    gasp_pkg::CFG_LOWEST_FIRST: lowest_first_reg <= cfg_data[0];
                    gasp_pkg::CFG_GRID_WIDTH:   grid_width_reg   <= cfg_data;
                    gasp_pkg::CFG_GRID_HEIGHT:  grid_height_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == T_RESP && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_CLR: begin
                    clr_reg <= clr_reg + (CW+1)'(1);
                    if (clr_reg == (CW+1)'(gasp_pkg::CELL_COUNT - 1)) state_reg <= T_IDLE;
                end
                T_IDLE: begin
                    res_x_reg <= '0;
                    res_y_reg <= '0;
                    if (accept) begin
                        unique case (s_opcode)
                            gasp_pkg::OP_WRITE: begin
                                res_status_reg <= in_grid ? gasp_pkg::ST_OK
                                                          : gasp_pkg::ST_RANGE;
                                state_reg      <= T_RESP;
                            end
                            gasp_pkg::OP_SEARCH: begin
                                found_length_reg <= '0;
                                cmd_reg <= '{sx: s_cell_x, sy: s_cell_y, gx: s_goal_x,
                                             gy: s_goal_y, w: side_w, h: side_h,
                                             lowest_first: lowest_first_reg};
                                state_reg <= T_SEARCH;
                            end
                            gasp_pkg::OP_READ: begin
                                if ({1'b0, s_path_index} < found_length_reg) begin
                                    state_reg <= T_READ;
                                end else begin
                                    res_status_reg <= gasp_pkg::ST_RANGE;
                                    state_reg      <= T_RESP;
                                end
                            end
                            default: begin
                                res_status_reg <= gasp_pkg::ST_RANGE;
                                state_reg      <= T_RESP;
                            end
                        endcase
                    end
                end
                T_READ: begin
                    res_status_reg <= gasp_pkg::ST_OK;
                    res_x_reg      <= path_rdata[XW-1:0];
                    res_y_reg      <= path_rdata[CW-1:XW];
                    state_reg      <= T_RESP;
                end
                T_SEARCH: begin
                    if (eng_done) begin
                        res_status_reg   <= eng_res.status;
                        found_length_reg <= eng_res.length;
                        state_reg        <= T_RESP;
                    end
                end
                T_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_status_reg <= res_status_reg;
                        m_len_reg    <= found_length_reg;
                        m_x_reg      <= res_x_reg;
                        m_y_reg      <= res_y_reg;
                        state_reg    <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_path_length = m_len_reg;
    assign m_step_x      = m_x_reg;
    assign m_step_y      = m_y_reg;

endmodule
